// ----- hw/rtl/acp_pkg.sv -----
// Shared types, codes and item tables for the category 020 block parser.
`default_nettype none
package acp_pkg;

    localparam int MAX_FSPEC_OCTETS = 4;
    localparam int NUM_ITEMS        = 28;
    localparam int QUEUE_DEPTH      = 4;

    localparam logic [1:0] KIND_CHUNK = 2'd0;
    localparam logic [1:0] KIND_OK    = 2'd1;
    localparam logic [1:0] KIND_ERROR = 2'd2;

    localparam logic [2:0] ERR_CATEGORY  = 3'd1;
    localparam logic [2:0] ERR_SHORT     = 3'd2;
    localparam logic [2:0] ERR_FSPEC_END = 3'd3;
    localparam logic [2:0] ERR_FSPEC_LEN = 3'd4;
    localparam logic [2:0] ERR_EXTENT    = 3'd5;
    localparam logic [2:0] ERR_SUBFIELD  = 3'd6;
    localparam logic [2:0] ERR_OVERRUN   = 3'd7;

    localparam logic [2:0] IK_FIX  = 3'd0;
    localparam logic [2:0] IK_EXT2 = 3'd1;
    localparam logic [2:0] IK_EXT  = 3'd2;
    localparam logic [2:0] IK_ACC  = 3'd3;
    localparam logic [2:0] IK_REP1 = 3'd4;
    localparam logic [2:0] IK_REP8 = 3'd5;
    localparam logic [2:0] IK_EXPL = 3'd6;

    typedef struct packed {
        logic [1:0]  kind;
        logic [4:0]  item_number;
        logic [63:0] payload;
        logic [3:0]  payload_bytes;
        logic [7:0]  element_index;
        logic [15:0] record_index;
        logic        last_of_record;
        logic [2:0]  error_code;
    } result_t;

    typedef struct packed {
        logic    v0;
        logic    v1;
        result_t r0;
        result_t r1;
    } push_t;

    function automatic logic [2:0] item_kind(input logic [4:0] it);
        logic [2:0] k;
        case (it)
            5'd1, 5'd6:   k = IK_EXT2;
            5'd18:        k = IK_ACC;
            5'd19:        k = IK_REP1;
            5'd20:        k = IK_REP8;
            5'd23:        k = IK_EXT;
            5'd26, 5'd27: k = IK_EXPL;
            default:      k = IK_FIX;
        endcase
        return k;
    endfunction

    function automatic logic [7:0] item_len(input logic [4:0] it);
        logic [7:0] n;
        case (it)
            5'd2, 5'd11:  n = 8'd3;
            5'd3:         n = 8'd8;
            5'd4:         n = 8'd6;
            5'd8, 5'd10:  n = 8'd4;
            5'd12, 5'd22: n = 8'd7;
            5'd0, 5'd5, 5'd7, 5'd9, 5'd13, 5'd14, 5'd15, 5'd21, 5'd25:
                          n = 8'd2;
            default:      n = 8'd1;
        endcase
        return n;
    endfunction

    function automatic push_t add_result(input push_t p, input result_t r);
        push_t q;
        q = p;
        if (!p.v0)
        begin
            q.v0 = 1'b1;
            q.r0 = r;
        end
        else
        begin
            q.v1 = 1'b1;
            q.r1 = r;
        end
        return q;
    endfunction

    function automatic result_t mk_result(input logic [1:0] kind, input logic [4:0] item,
                                          input logic [63:0] pl, input logic [3:0] nb,
                                          input logic [7:0] elem, input logic [15:0] rec,
                                          input logic last, input logic [2:0] err);
        result_t r;
        r.kind           = kind;
        r.item_number    = item;
        r.payload        = pl;
        r.payload_bytes  = nb;
        r.element_index  = elem;
        r.record_index   = rec;
        r.last_of_record = last;
        r.error_code     = err;
        return r;
    endfunction

endpackage
`default_nettype wire

// ----- hw/rtl/acp_front.sv -----
// Byte parser: walks header, FSPEC and item bytes and forms up to two results per byte.
`default_nettype none
module acp_front
    import acp_pkg::*;
#(
    parameter int CHUNK_BYTES = 8
)
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       fire,
    input  wire logic [7:0] data_byte,
    input  wire logic       frame_end,
    input  wire logic [7:0] expected_category,
    output push_t           push
);

    localparam logic [2:0] PH_HDR0  = 3'd0;
    localparam logic [2:0] PH_HDR1  = 3'd1;
    localparam logic [2:0] PH_HDR2  = 3'd2;
    localparam logic [2:0] PH_FSPEC = 3'd3;
    localparam logic [2:0] PH_START = 3'd4;
    localparam logic [2:0] PH_BODY  = 3'd5;
    localparam logic [2:0] PH_DRAIN = 3'd6;

    localparam logic [3:0] CHUNK_FULL = 4'(CHUNK_BYTES);

    logic [2:0]  phase_reg, phase_next;
    logic [15:0] declared_length_reg, declared_length_next;
    logic [15:0] byte_count_reg, byte_count_next;
    logic [31:0] fspec_bits_reg, fspec_bits_next;
    logic [2:0]  fspec_octets_reg, fspec_octets_next;
    logic [4:0]  current_item_reg, current_item_next;
    logic [7:0]  bytes_left_reg, bytes_left_next;
    logic [63:0] chunk_buffer_reg, chunk_buffer_next;
    logic [3:0]  chunk_fill_reg, chunk_fill_next;
    logic [7:0]  element_count_reg, element_count_next;
    logic [7:0]  repeats_left_reg, repeats_left_next;
    logic [15:0] record_count_reg, record_count_next;

    push_t       pq;
    logic [2:0]  k;
    logic        first, seg, iend, rec_done, nx_found;
    logic [2:0]  err;
    logic [4:0]  nx;
    logic [15:0] dl;
    logic [7:0]  per;

    function automatic logic [27:0] presence(input logic [31:0] fb);
        logic [27:0] p;
        for (int i = 0; i < NUM_ITEMS; i++)
        begin
            p[i] = fb[31 - 8 * (i / 7) - (i % 7)];
        end
        return p;
    endfunction

    // Lowest present item at or above from.
    function automatic logic [5:0] find_item(input logic [31:0] fb, input logic [4:0] from);
        logic [27:0] p;
        logic [5:0]  r;
        p = presence(fb);
        r = '0;
        for (int i = NUM_ITEMS - 1; i >= 0; i--)
        begin
            if (p[i] && (5'(i) >= from))
            begin
                r = {1'b1, 5'(i)};
            end
        end
        return r;
    endfunction

    always_comb
    begin
        phase_next           = phase_reg;
        declared_length_next = declared_length_reg;
        byte_count_next      = byte_count_reg;
        fspec_bits_next      = fspec_bits_reg;
        fspec_octets_next    = fspec_octets_reg;
        current_item_next    = current_item_reg;
        bytes_left_next      = bytes_left_reg;
        chunk_buffer_next    = chunk_buffer_reg;
        chunk_fill_next      = chunk_fill_reg;
        element_count_next   = element_count_reg;
        repeats_left_next    = repeats_left_reg;
        record_count_next    = record_count_reg;
        pq       = '0;
        k        = item_kind(current_item_reg);
        first    = (phase_reg == PH_START);
        seg      = 1'b0;
        iend     = 1'b0;
        rec_done = 1'b0;
        err      = '0;
        nx       = '0;
        nx_found = 1'b0;
        dl       = '0;
        per      = '0;

        if (phase_reg != PH_DRAIN)
        begin
            byte_count_next = byte_count_reg + 16'd1;
        end

        case (phase_reg)
            PH_HDR0:
            begin
                if (data_byte != expected_category)
                begin
                    pq = add_result(pq, mk_result(KIND_ERROR, '0, '0, '0, '0,
                                                  record_count_reg, 1'b0, ERR_CATEGORY));
                    phase_next = PH_DRAIN;
                end
                else
                begin
                    phase_next = PH_HDR1;
                end
            end
            PH_HDR1:
            begin
                declared_length_next = {data_byte, 8'd0};
                phase_next = PH_HDR2;
            end
            PH_HDR2:
            begin
                dl = {declared_length_reg[15:8], data_byte};
                declared_length_next = dl;
                if (dl < 16'd3)
                begin
                    pq = add_result(pq, mk_result(KIND_ERROR, '0, '0, '0, '0,
                                                  record_count_reg, 1'b0, ERR_OVERRUN));
                    phase_next = PH_DRAIN;
                end
                else if (dl == 16'd3)
                begin
                    pq = add_result(pq, mk_result(KIND_OK, '0, '0, '0, '0,
                                                  record_count_reg, 1'b0, 3'd0));
                    phase_next = PH_DRAIN;
                end
                else
                begin
                    fspec_bits_next   = '0;
                    fspec_octets_next = '0;
                    current_item_next = '0;
                    phase_next        = PH_FSPEC;
                end
            end
            PH_FSPEC:
            begin
                fspec_bits_next = fspec_bits_reg
                                | ({24'd0, data_byte} << (5'd24 - {fspec_octets_reg[1:0], 3'd0}));
                fspec_octets_next = fspec_octets_reg + 3'd1;
                if (data_byte[0])
                begin
                    if (fspec_octets_next >= 3'(MAX_FSPEC_OCTETS))
                    begin
                        pq = add_result(pq, mk_result(KIND_ERROR, '0, '0, '0, '0,
                                                      record_count_reg, 1'b0, ERR_FSPEC_LEN));
                        phase_next = PH_DRAIN;
                    end
                    else if (byte_count_next >= declared_length_reg)
                    begin
                        pq = add_result(pq, mk_result(KIND_ERROR, '0, '0, '0, '0,
                                                      record_count_reg, 1'b0, ERR_FSPEC_END));
                        phase_next = PH_DRAIN;
                    end
                end
                else
                begin
                    {nx_found, nx} = find_item(fspec_bits_next, 5'd0);
                    if (!nx_found)
                    begin
                        // empty record: count it and start the next one
                        record_count_next = record_count_reg + 16'd1;
                        fspec_bits_next   = '0;
                        fspec_octets_next = '0;
                        current_item_next = '0;
                        if (byte_count_next >= declared_length_reg)
                        begin
                            pq = add_result(pq, mk_result(KIND_OK, '0, '0, '0, '0,
                                                          record_count_next, 1'b0, 3'd0));
                            phase_next = PH_DRAIN;
                        end
                    end
                    else
                    begin
                        current_item_next = nx;
                        phase_next        = PH_START;
                        if (byte_count_next >= declared_length_reg)
                        begin
                            pq = add_result(pq, mk_result(KIND_ERROR, '0, '0, '0, '0,
                                                          record_count_reg, 1'b0, ERR_OVERRUN));
                            phase_next = PH_DRAIN;
                        end
                    end
                end
            end
            PH_START, PH_BODY:
            begin
                if (!first && (bytes_left_reg != 8'd0) && (k != IK_EXT2) && (k != IK_EXT))
                begin
                    bytes_left_next = bytes_left_reg - 8'd1;
                end
                per = (k == IK_REP1) ? 8'd1 : 8'd8;
                case (k)
                    IK_EXT2:
                    begin
                        if (!first && data_byte[0])
                        begin
                            err = ERR_EXTENT;
                        end
                        else
                        begin
                            seg  = 1'b1;
                            iend = !data_byte[0];
                        end
                    end
                    IK_EXT:
                    begin
                        seg  = 1'b1;
                        iend = !data_byte[0];
                    end
                    IK_ACC:
                    begin
                        if (first && (data_byte[4:0] != 5'd0))
                        begin
                            err = ERR_SUBFIELD;
                        end
                        else
                        begin
                            if (first)
                            begin
                                bytes_left_next = (data_byte[7] ? 8'd6 : 8'd0)
                                                + (data_byte[6] ? 8'd6 : 8'd0)
                                                + (data_byte[5] ? 8'd2 : 8'd0);
                            end
                            iend = (bytes_left_next == 8'd0);
                            seg  = iend;
                        end
                    end
                    IK_REP1, IK_REP8:
                    begin
                        if (first)
                        begin
                            repeats_left_next = data_byte;
                            seg = 1'b1;
                            if (data_byte == 8'd0)
                            begin
                                iend = 1'b1;
                            end
                            else
                            begin
                                bytes_left_next = per;
                            end
                        end
                        else if (bytes_left_next == 8'd0)
                        begin
                            seg = 1'b1;
                            if (repeats_left_reg != 8'd0)
                            begin
                                repeats_left_next = repeats_left_reg - 8'd1;
                            end
                            if (repeats_left_next == 8'd0)
                            begin
                                iend = 1'b1;
                            end
                            else
                            begin
                                bytes_left_next = per;
                            end
                        end
                    end
                    IK_EXPL:
                    begin
                        if (first)
                        begin
                            bytes_left_next = (data_byte == 8'd0) ? 8'd0 : data_byte - 8'd1;
                        end
                        iend = (bytes_left_next == 8'd0);
                        seg  = iend;
                    end
                    default:
                    begin
                        if (first)
                        begin
                            bytes_left_next = item_len(current_item_reg) - 8'd1;
                        end
                        iend = (bytes_left_next == 8'd0);
                        seg  = iend;
                    end
                endcase

                if (err != 3'd0)
                begin
                    pq = add_result(pq, mk_result(KIND_ERROR, '0, '0, '0, '0,
                                                  record_count_reg, 1'b0, err));
                    phase_next = PH_DRAIN;
                end
                else
                begin
                    if (first)
                    begin
                        element_count_next = '0;
                    end
                    phase_next        = PH_BODY;
                    chunk_buffer_next = {chunk_buffer_reg[55:0], data_byte};
                    chunk_fill_next   = chunk_fill_reg + 4'd1;
                    if (iend)
                    begin
                        {nx_found, nx} = find_item(fspec_bits_reg, current_item_reg + 5'd1);
                        if (nx_found)
                        begin
                            current_item_next = nx;
                            phase_next        = PH_START;
                        end
                        else
                        begin
                            rec_done = 1'b1;
                        end
                    end
                    if (seg || (chunk_fill_next >= CHUNK_FULL))
                    begin
                        pq = add_result(pq, mk_result(KIND_CHUNK, current_item_reg,
                                                      chunk_buffer_next, chunk_fill_next,
                                                      element_count_next, record_count_reg,
                                                      rec_done, 3'd0));
                        element_count_next = element_count_next + 8'd1;
                        chunk_buffer_next  = '0;
                        chunk_fill_next    = '0;
                    end
                    if (rec_done)
                    begin
                        record_count_next = record_count_reg + 16'd1;
                        fspec_bits_next   = '0;
                        fspec_octets_next = '0;
                        current_item_next = '0;
                        phase_next        = PH_FSPEC;
                    end
                    if (byte_count_next >= declared_length_reg)
                    begin
                        if (rec_done)
                        begin
                            pq = add_result(pq, mk_result(KIND_OK, '0, '0, '0, '0,
                                                          record_count_next, 1'b0, 3'd0));
                        end
                        else
                        begin
                            // drop partial chunk bytes
                            pq = add_result(pq, mk_result(KIND_ERROR, '0, '0, '0, '0,
                                                          record_count_next, 1'b0,
                                                          ERR_OVERRUN));
                        end
                        phase_next = PH_DRAIN;
                    end
                end
            end
            default:
            begin
                phase_next = PH_DRAIN;
            end
        endcase

        if (frame_end)
        begin
            if (phase_next != PH_DRAIN)
            begin
                pq = add_result(pq, mk_result(KIND_ERROR, '0, '0, '0, '0,
                                              record_count_next, 1'b0, ERR_SHORT));
            end
            phase_next           = PH_HDR0;
            declared_length_next = '0;
            byte_count_next      = '0;
            fspec_bits_next      = '0;
            fspec_octets_next    = '0;
            current_item_next    = '0;
            bytes_left_next      = '0;
            chunk_buffer_next    = '0;
            chunk_fill_next      = '0;
            element_count_next   = '0;
            repeats_left_next    = '0;
            record_count_next    = '0;
        end

        pq.v0 = pq.v0 & fire;
        pq.v1 = pq.v1 & fire;
    end

    assign push = pq;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg           <= PH_HDR0;
            declared_length_reg <= '0;
            byte_count_reg      <= '0;
            fspec_bits_reg      <= '0;
            fspec_octets_reg    <= '0;
            current_item_reg    <= '0;
            bytes_left_reg      <= '0;
            chunk_buffer_reg    <= '0;
            chunk_fill_reg      <= '0;
            element_count_reg   <= '0;
            repeats_left_reg    <= '0;
            record_count_reg    <= '0;
        end
        else if (fire)
        begin
            phase_reg           <= phase_next;
            declared_length_reg <= declared_length_next;
            byte_count_reg      <= byte_count_next;
            fspec_bits_reg      <= fspec_bits_next;
            fspec_octets_reg    <= fspec_octets_next;
            current_item_reg    <= current_item_next;
            bytes_left_reg      <= bytes_left_next;
            chunk_buffer_reg    <= chunk_buffer_next;
            chunk_fill_reg      <= chunk_fill_next;
            element_count_reg   <= element_count_next;
            repeats_left_reg    <= repeats_left_next;
            record_count_reg    <= record_count_next;
        end
    end

endmodule
`default_nettype wire

// ----- hw/rtl/acp_queue.sv -----
// Result queue: takes up to two results per cycle, hands out one per transaction.
`default_nettype none
module acp_queue
    import acp_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire push_t push,
    output logic       room,
    output logic       out_valid,
    input  wire logic  out_ready,
    output result_t    head
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    result_t            mem [QUEUE_DEPTH];
    logic [PTR_W-1:0]   wp_reg, wp_next, rp_reg, rp_next;
    logic [CNT_W-1:0]   count_reg, count_next, n_push;
    logic               pop;

    assign out_valid = (count_reg != '0);
    assign room      = (count_reg <= CNT_W'(QUEUE_DEPTH - 2));
    assign head      = mem[rp_reg];
    assign pop       = out_valid && out_ready;
    assign n_push    = CNT_W'(push.v0) + CNT_W'(push.v1);

    always_comb
    begin
        wp_next    = wp_reg + PTR_W'(n_push);
        rp_next    = pop ? rp_reg + PTR_W'(1) : rp_reg;
        count_next = count_reg + n_push - CNT_W'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push.v0)
        begin
            mem[wp_reg] <= push.r0;
        end
        if (push.v1)
        begin
            mem[wp_reg + PTR_W'(1)] <= push.r1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg    <= '0;
            rp_reg    <= '0;
            count_reg <= '0;
        end
        else
        begin
            wp_reg    <= wp_next;
            rp_reg    <= rp_next;
            count_reg <= count_next;
        end
    end

endmodule
`default_nettype wire

// ----- hw/rtl/asterix_cat020_block_parser_top.sv -----
// Top level of the category 020 data block parser.
//
// Input channel (in_valid/in_ready): one byte of a data block per transaction,
// with frame_end marking the last byte of the received buffer.
// Output channel (out_valid/out_ready): one result per transaction: an item
// chunk of up to CHUNK_BYTES raw bytes, a block ok, or an error. After an
// error the consumer discards everything it took from that block.
// cfg_write/cfg_data set the expected category byte (20 after reset); write
// it only while no block is in progress.
// Results of a byte are written into the result queue on the byte's
// transaction. Throughput: one byte per cycle; a byte gives at most two
// results, so the output side drains one result per cycle from a four-entry
// queue, and in_ready drops while that queue has fewer than two free entries.
// When the receiver stalls, the queue fills and input is held off; nothing
// is lost. Reset clears the parser to the start of a block and empties the
// queue; there is no clearing pass.
`default_nettype none
module asterix_cat020_block_parser_top
    import acp_pkg::*;
#(
    parameter int CHUNK_BYTES = 8
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_write,
    input  wire logic [7:0]  cfg_data,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [7:0]  data_byte,
    input  wire logic        frame_end,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [1:0]       kind,
    output logic [4:0]       item_number,
    output logic [63:0]      payload,
    output logic [3:0]       payload_bytes,
    output logic [7:0]       element_index,
    output logic [15:0]      record_index,
    output logic             last_of_record,
    output logic [2:0]       error_code
);

    logic [7:0] category_reg;
    logic       fire;
    push_t      push;
    result_t    head;

    assign fire = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            category_reg <= 8'd20;
        end
        else if (cfg_write)
        begin
            category_reg <= cfg_data;
        end
    end

    acp_front #(
        .CHUNK_BYTES(CHUNK_BYTES)
    ) u_front (
        .clk              (clk),
        .rst_n            (rst_n),
        .fire             (fire),
        .data_byte        (data_byte),
        .frame_end        (frame_end),
        .expected_category(category_reg),
        .push             (push)
    );

    acp_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .room     (in_ready),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .head     (head)
    );

    assign kind           = head.kind;
    assign item_number    = head.item_number;
    assign payload        = head.payload;
    assign payload_bytes  = head.payload_bytes;
    assign element_index  = head.element_index;
    assign record_index   = head.record_index;
    assign last_of_record = head.last_of_record;
    assign error_code     = head.error_code;

endmodule
`default_nettype wire
